FILE: sv/lkof_pkg.sv
`timescale 1ns / 1ps
// Shared widths, payload types and register codes for the optical flow block.
// No dependencies.
package lkof_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int FRAC_BITS = 8;
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = 12;
  localparam int WCW       = 11;
  localparam int HCW       = 12;
  localparam int CDW       = 12;
  localparam int PXW       = 8;
  localparam int GW        = 11;          // fx, fy, ft
  localparam int SW        = 23;          // sum of three products
  localparam int TW        = 25;          // 3x3 window total
  localparam int MW        = 2 * TW;      // window product
  localparam int NW        = MW + 1;      // determinant and numerators
  localparam int DW        = 48;          // positive determinant
  localparam int QB        = 17;          // quotient bits kept
  localparam int SH        = QB - FRAC_BITS;
  localparam int CW        = NW + SH;
  localparam int CNTW      = $clog2(QB + 1);
  localparam int OW        = 16;

  localparam logic [WCW-1:0] RESET_WIDTH  = WCW'(640);
  localparam logic [HCW-1:0] RESET_HEIGHT = HCW'(480);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic signed [GW-1:0] grad_t;
  typedef logic signed [SW-1:0] csum_t;
  typedef logic signed [TW-1:0] tsum_t;

  typedef struct packed {
    grad_t fx;
    grad_t fy;
    grad_t ft;
  } grad3_t;

  typedef struct packed {
    csum_t xx;
    csum_t yy;
    csum_t xy;
    csum_t xt;
    csum_t yt;
  } csum5_t;

  typedef struct packed {
    tsum_t xx;
    tsum_t yy;
    tsum_t xy;
    tsum_t xt;
    tsum_t yt;
  } tsum5_t;

  // One interior pixel handed from front to back
  typedef struct packed {
    tsum5_t          t;
    logic [YW-1:0]   row;
    logic [XW-1:0]   col;
    logic            last;
  } work_t;

endpackage

FILE: sv/lkof_pix_if.sv
`timescale 1ns / 1ps
// Pixel pair channel: valid/ready plus both frames' pixels and frame start.
// Depends on nothing.
interface lkof_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_first;
  logic [7:0] pixel_second;
  logic       frame_start;

  modport source (output valid, pixel_first, pixel_second, frame_start, input ready);
  modport sink   (input valid, pixel_first, pixel_second, frame_start, output ready);
endinterface

FILE: sv/lkof_flow_if.sv
`timescale 1ns / 1ps
// Flow result channel: valid/ready plus flow vector, position and flags.
// Depends on nothing.
interface lkof_flow_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] flow_u;
  logic signed [15:0] flow_v;
  logic [11:0]        out_row;
  logic [9:0]         out_col;
  logic               singular;
  logic               last_of_frame;

  modport source (output valid, flow_u, flow_v, out_row, out_col, singular, last_of_frame,
                  input ready);
  modport sink   (input valid, flow_u, flow_v, out_row, out_col, singular, last_of_frame,
                  output ready);
endinterface

FILE: sv/lkof_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel: valid/ready, register index and write data.
// Depends on nothing.
interface lkof_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lucas_kanade_optical_flow.sv
`timescale 1ns / 1ps
// A pixel pair passes the front states GRAD, PROD and SUM into the queue; the back then
// runs MUL, DIFF, LOAD, the 17-step divider and OUT. The front takes a new pixel pair only
// after finishing the last one and while the queue is not full; the back takes one window at a time.
// A two-entry queue lets the front keep going while the back divides.
// Reset: position, window sums and sequencers clear; size registers go to 640x480;
// row buffers are not cleared.
module lucas_kanade_optical_flow (
  input  logic        clk,
  input  logic        rst,
  lkof_pix_if.sink    pix,
  lkof_flow_if.source flow,
  lkof_cfg_if.sink    cfg
);

  logic [lkof_pkg::WCW-1:0] image_width;
  logic [lkof_pkg::HCW-1:0] image_height;
  logic                     q_push, q_full, q_pop, q_valid;
  lkof_pkg::work_t          push_data, pop_data;

  assign cfg.ready = 1'b1;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lkof_pkg::RESET_WIDTH;
      image_height <= lkof_pkg::RESET_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      case (lkof_pkg::reg_idx_t'(cfg.index))
        lkof_pkg::REG_WIDTH:  image_width  <= cfg.data[lkof_pkg::WCW-1:0];
        lkof_pkg::REG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  lkof_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .image_width  (image_width),
    .image_height (image_height),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  lkof_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  lkof_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .flow    (flow)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window pushed into a full queue");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |-> !q_full)
    else $error("pixel beat taken while queue full");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (flow.valid && flow.singular) |-> (flow.flow_u == '0 && flow.flow_v == '0))
    else $error("singular result with nonzero flow");
`endif

endmodule

FILE: sv/lkof_front.sv
`timescale 1ns / 1ps
// Front end: takes pixel pairs, keeps row buffers, forms gradients and window sums.
// Depends on lkof_pkg and lkof_pix_if.
module lkof_front (
  input  logic                       clk,
  input  logic                       rst,
  lkof_pix_if.sink                   pix,
  input  logic [lkof_pkg::WCW-1:0]   image_width,
  input  logic [lkof_pkg::HCW-1:0]   image_height,
  input  logic                       q_full,
  output logic                       q_push,
  output lkof_pkg::work_t            q_data
);

  typedef enum logic [1:0] {F_IDLE, F_GRAD, F_PROD, F_SUM} fstate_t;

  fstate_t                       state;
  logic [lkof_pkg::YW-1:0]       row_counter, row_counter_next;
  logic [lkof_pkg::XW-1:0]       col_counter, col_counter_next;
  logic [lkof_pkg::YW-1:0]       y, y_cur;
  logic [lkof_pkg::XW-1:0]       x, x_cur;
  logic                          last, last_cur;
  logic [7:0]                    ca, cb;
  logic [7:0]                    left_a, left_b, upleft_a, upleft_b;
  logic [lkof_pkg::WCW-1:0]      w_eff;
  logic [lkof_pkg::HCW-1:0]      h_eff;
  logic                          x_end, y_end, acc;
  logic                          grad_en, sum_en;

  logic [15:0]                   prev_mem [lkof_pkg::MAX_WIDTH];
  lkof_pkg::grad3_t              g0_mem   [lkof_pkg::MAX_WIDTH];
  lkof_pkg::grad3_t              g1_mem   [lkof_pkg::MAX_WIDTH];
  logic [15:0]                   prev_rd;
  lkof_pkg::grad3_t              g0_rd, g1_rd;

  lkof_pkg::grad3_t              gnew, gcur, goth, ga, gb, gc;
  lkof_pkg::csum5_t              pa, pb, pc, s, w1, w2;
  lkof_pkg::tsum5_t              t;

  function automatic lkof_pkg::grad_t ext8(input logic [7:0] v);
    lkof_pkg::grad_t r;
    r = lkof_pkg::grad_t'({{(lkof_pkg::GW - 8){1'b0}}, v});
    return r;
  endfunction

  function automatic lkof_pkg::csum_t wid(input lkof_pkg::grad_t v);
    lkof_pkg::csum_t r;
    r = v;
    return r;
  endfunction

  function automatic lkof_pkg::csum5_t prod5(input lkof_pkg::grad3_t g);
    lkof_pkg::csum5_t r;
    r.xx = wid(g.fx) * wid(g.fx);
    r.yy = wid(g.fy) * wid(g.fy);
    r.xy = wid(g.fx) * wid(g.fy);
    r.xt = wid(g.fx) * wid(g.ft);
    r.yt = wid(g.fy) * wid(g.ft);
    return r;
  endfunction

  function automatic lkof_pkg::tsum_t tx(input lkof_pkg::csum_t v);
    lkof_pkg::tsum_t r;
    r = v;
    return r;
  endfunction

  // Clamp the frame size registers
  always_comb begin
    if (image_width < lkof_pkg::WCW'(3)) begin
      w_eff = lkof_pkg::WCW'(3);
    end else if (image_width > lkof_pkg::WCW'(lkof_pkg::MAX_WIDTH)) begin
      w_eff = lkof_pkg::WCW'(lkof_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height < lkof_pkg::HCW'(3)) ? lkof_pkg::HCW'(3) : image_height;
  end

  // Position of the incoming beat and the next one
  always_comb begin
    acc      = pix.valid && pix.ready;
    x_cur    = pix.frame_start ? '0 : col_counter;
    y_cur    = pix.frame_start ? '0 : row_counter;
    x_end    = ({1'b0, x_cur} + lkof_pkg::WCW'(1)) >= w_eff;
    y_end    = ({1'b0, y_cur} + (lkof_pkg::YW + 1)'(1)) >= {1'b0, h_eff};
    last_cur = x_end && y_end;
    if (x_end) begin
      col_counter_next = '0;
      row_counter_next = y_end ? '0 : y_cur + lkof_pkg::YW'(1);
    end else begin
      col_counter_next = x_cur + lkof_pkg::XW'(1);
      row_counter_next = y_cur;
    end
  end

  assign pix.ready = (state == F_IDLE) && !q_full;
  assign grad_en   = (y != '0) && (x != '0);
  assign sum_en    = grad_en && (y != lkof_pkg::YW'(1));

  // Gradients from the 2x2 block of both frames
  always_comb begin
    lkof_pkg::grad_t aa, ab, a0, b0, la, lb, ula, ulb;
    aa  = ext8(prev_rd[15:8]);
    ab  = ext8(prev_rd[7:0]);
    a0  = ext8(ca);
    b0  = ext8(cb);
    la  = ext8(left_a);
    lb  = ext8(left_b);
    ula = ext8(upleft_a);
    ulb = ext8(upleft_b);
    gnew.fx = (aa - ula) + (a0 - la) + (ab - ulb) + (b0 - lb);
    gnew.fy = (la + a0) - (ula + aa) + (lb + b0) - (ulb + ab);
    gnew.ft = (ulb + ab + lb + b0) - (ula + aa + la + a0);
    gcur    = y[0] ? g1_rd : g0_rd;
    goth    = y[0] ? g0_rd : g1_rd;
  end

  // Column sums and window totals
  always_comb begin
    s.xx = pa.xx + pb.xx + pc.xx;
    s.yy = pa.yy + pb.yy + pc.yy;
    s.xy = pa.xy + pb.xy + pc.xy;
    s.xt = pa.xt + pb.xt + pc.xt;
    s.yt = pa.yt + pb.yt + pc.yt;
    t.xx = tx(w1.xx) + tx(w2.xx) + tx(s.xx);
    t.yy = tx(w1.yy) + tx(w2.yy) + tx(s.yy);
    t.xy = tx(w1.xy) + tx(w2.xy) + tx(s.xy);
    t.xt = tx(w1.xt) + tx(w2.xt) + tx(s.xt);
    t.yt = tx(w1.yt) + tx(w2.yt) + tx(s.yt);
    q_push      = (state == F_SUM) && sum_en && (x != lkof_pkg::XW'(1));
    q_data.t    = t;
    q_data.row  = y - lkof_pkg::YW'(1);
    q_data.col  = x - lkof_pkg::XW'(1);
    q_data.last = last;
  end

  // Row buffers: read on accept, write back in the gradient step
  always_ff @(posedge clk) begin
    if (acc) begin
      prev_rd <= prev_mem[x_cur];
      g0_rd   <= g0_mem[x_cur];
      g1_rd   <= g1_mem[x_cur];
    end
    if (state == F_GRAD) begin
      prev_mem[x] <= {ca, cb};
      if (grad_en && !y[0]) begin
        g0_mem[x] <= gnew;
      end
      if (grad_en && y[0]) begin
        g1_mem[x] <= gnew;
      end
    end
  end

  // Sequencer, position, neighbour pixels and window
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      row_counter <= '0;
      col_counter <= '0;
      left_a      <= '0;
      left_b      <= '0;
      upleft_a    <= '0;
      upleft_b    <= '0;
      w1          <= '0;
      w2          <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (acc) begin
            ca          <= pix.pixel_first;
            cb          <= pix.pixel_second;
            x           <= x_cur;
            y           <= y_cur;
            last        <= last_cur;
            col_counter <= col_counter_next;
            row_counter <= row_counter_next;
            state       <= F_GRAD;
          end
        end
        F_GRAD: begin
          upleft_a <= prev_rd[15:8];
          upleft_b <= prev_rd[7:0];
          left_a   <= ca;
          left_b   <= cb;
          // row 0 mirrors row 1: fy changes sign
          if (y == lkof_pkg::YW'(2)) begin
            ga.fx <= goth.fx;
            ga.fy <= -goth.fy;
            ga.ft <= goth.ft;
          end else begin
            ga <= gcur;
          end
          gb    <= goth;
          gc    <= gnew;
          state <= F_PROD;
        end
        F_PROD: begin
          pa    <= prod5(ga);
          pb    <= prod5(gb);
          pc    <= prod5(gc);
          state <= F_SUM;
        end
        F_SUM: begin
          if (sum_en) begin
            w2 <= s;
            // column 0 mirrors column 1: fx changes sign
            if (x == lkof_pkg::XW'(1)) begin
              w1.xx <= s.xx;
              w1.yy <= s.yy;
              w1.xy <= -s.xy;
              w1.xt <= -s.xt;
              w1.yt <= s.yt;
            end else begin
              w1 <= w2;
            end
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/lkof_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of window totals between front and back.
// Depends on lkof_pkg.
module lkof_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lkof_pkg::work_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lkof_pkg::work_t  pop_data
);

  lkof_pkg::work_t entry [2];
  logic            wr_ptr, rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/lkof_div.sv
`timescale 1ns / 1ps
// Restoring divider: |num| * 2^FRAC_BITS / den, one quotient bit a cycle,
// then sign and 16-bit saturation. Depends on lkof_pkg.
module lkof_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lkof_pkg::NW-1:0]      num,
  input  logic [lkof_pkg::DW-1:0]             den,
  output logic                                done,
  output logic signed [lkof_pkg::OW-1:0]      quo
);

  logic                          busy;
  logic [lkof_pkg::CNTW-1:0]     count;
  logic [lkof_pkg::DW-1:0]       rem;
  logic [lkof_pkg::QB-1:0]       low, q, qn;
  logic                          neg, sat;
  logic [lkof_pkg::NW-1:0]       mag;
  logic [lkof_pkg::DW:0]         trial, diff;
  logic                          ge;

  always_comb begin
    mag   = num[lkof_pkg::NW-1] ? lkof_pkg::NW'(-num) : lkof_pkg::NW'(num);
    trial = {rem, low[lkof_pkg::QB-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
    qn    = -q;
  end

  // Sign and saturate the quotient
  always_comb begin
    if (neg) begin
      if (sat || q > lkof_pkg::QB'(32768)) begin
        quo = lkof_pkg::OW'(16'sh8000);
      end else begin
        quo = qn[lkof_pkg::OW-1:0];
      end
    end else begin
      if (sat || q > lkof_pkg::QB'(32767)) begin
        quo = lkof_pkg::OW'(16'sh7FFF);
      end else begin
        quo = q[lkof_pkg::OW-1:0];
      end
    end
  end

  // Load operands, then shift in one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= lkof_pkg::CNTW'(lkof_pkg::QB);
        neg   <= num[lkof_pkg::NW-1];
        sat   <= lkof_pkg::CW'(mag) >= lkof_pkg::CW'({den, {lkof_pkg::SH{1'b0}}});
        rem   <= lkof_pkg::DW'(mag >> lkof_pkg::SH);
        low   <= {mag[lkof_pkg::SH-1:0], {lkof_pkg::FRAC_BITS{1'b0}}};
        q     <= '0;
      end else if (busy) begin
        rem   <= ge ? diff[lkof_pkg::DW-1:0] : trial[lkof_pkg::DW-1:0];
        q     <= {q[lkof_pkg::QB-2:0], ge};
        low   <= {low[lkof_pkg::QB-2:0], 1'b0};
        count <= count - lkof_pkg::CNTW'(1);
        if (count == lkof_pkg::CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/lkof_back.sv
`timescale 1ns / 1ps
// Back end: Cramer's rule on the window totals, two dividers, output register.
// Depends on lkof_pkg, lkof_div and lkof_flow_if.
module lkof_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  lkof_pkg::work_t     q_data,
  output logic                q_pop,
  lkof_flow_if.source         flow
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIFF, B_LOAD, B_DIV, B_OUT} bstate_t;

  bstate_t                              state;
  lkof_pkg::work_t                      work;
  logic signed [lkof_pkg::MW-1:0]       p_xxyy, p_xyxy, p_xyyt, p_yyxt, p_xtxy, p_xxyt;
  logic signed [lkof_pkg::NW-1:0]       det, nu, nv;
  logic                                 singular;
  logic                                 div_start, u_done, v_done;
  logic signed [lkof_pkg::OW-1:0]       u_quo, v_quo;
  logic                                 out_load;

  function automatic logic signed [lkof_pkg::MW-1:0] wm(input lkof_pkg::tsum_t v);
    logic signed [lkof_pkg::MW-1:0] r;
    r = v;
    return r;
  endfunction

  function automatic logic signed [lkof_pkg::NW-1:0] wn(
      input logic signed [lkof_pkg::MW-1:0] v);
    logic signed [lkof_pkg::NW-1:0] r;
    r = v;
    return r;
  endfunction

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign div_start = (state == B_LOAD);
  assign singular  = det[lkof_pkg::NW-1] || (det == '0);
  assign out_load  = (state == B_OUT) && (!flow.valid || flow.ready);

  lkof_div u_div_u (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nu),
    .den   (det[lkof_pkg::DW-1:0]),
    .done  (u_done),
    .quo   (u_quo)
  );

  lkof_div u_div_v (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nv),
    .den   (det[lkof_pkg::DW-1:0]),
    .done  (v_done),
    .quo   (v_quo)
  );

  // Sequence one window through products, differences and division
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      flow.valid <= 1'b0;
    end else begin
      if (out_load) begin
        flow.valid <= 1'b1;
      end else if (flow.valid && flow.ready) begin
        flow.valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            work  <= q_data;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          p_xxyy <= wm(work.t.xx) * wm(work.t.yy);
          p_xyxy <= wm(work.t.xy) * wm(work.t.xy);
          p_xyyt <= wm(work.t.xy) * wm(work.t.yt);
          p_yyxt <= wm(work.t.yy) * wm(work.t.xt);
          p_xtxy <= wm(work.t.xt) * wm(work.t.xy);
          p_xxyt <= wm(work.t.xx) * wm(work.t.yt);
          state  <= B_DIFF;
        end
        B_DIFF: begin
          det   <= wn(p_xxyy) - wn(p_xyxy);
          nu    <= wn(p_xyyt) - wn(p_yyxt);
          nv    <= wn(p_xtxy) - wn(p_xxyt);
          state <= B_LOAD;
        end
        B_LOAD: begin
          state <= B_DIV;
        end
        B_DIV: begin
          if (u_done && v_done) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            flow.flow_u        <= singular ? '0 : u_quo;
            flow.flow_v        <= singular ? '0 : v_quo;
            flow.singular      <= singular;
            flow.out_row       <= work.row;
            flow.out_col       <= work.col;
            flow.last_of_frame <= work.last;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for lucas_kanade_optical_flow: drives pixel-pair frames and frame sizes,
// predicts every flow result in-house and checks each one. Depends on lkof_pkg and
// the pixel, flow and register channel interfaces.
module tb_top;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    logic [11:0] row;
    logic [9:0]  col;
    logic        singular;
    logic        last;
  } flow_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lkof_pix_if  pix ();
  lkof_flow_if flow ();
  lkof_cfg_if  cfg ();

  lucas_kanade_optical_flow dut (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .flow (flow),
    .cfg  (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: frame size, row buffers, gradient rows, column sums, position
  int unsigned size_w = 640;
  int unsigned size_h = 480;
  logic [7:0]  line_a [lkof_pkg::MAX_WIDTH];
  logic [7:0]  line_b [lkof_pkg::MAX_WIDTH];
  int          grad_x [2*lkof_pkg::MAX_WIDTH];
  int          grad_y [2*lkof_pkg::MAX_WIDTH];
  int          grad_t [2*lkof_pkg::MAX_WIDTH];
  longint      col_sums [3][5];
  longint      col_acc [5];
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  int          left_a = 0, left_b = 0, upleft_a = 0, upleft_b = 0;

  flow_beat_t  flow_expected[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int unsigned items_sent = 0;

  initial begin
    foreach (line_a[i]) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    foreach (grad_x[i]) begin
      grad_x[i] = 0;
      grad_y[i] = 0;
      grad_t[i] = 0;
    end
    foreach (col_sums[i, k]) col_sums[i][k] = 0;
  end

  function automatic void acc_products(int fx, int fy, int ft);
    col_acc[0] += longint'(fx) * fx;
    col_acc[1] += longint'(fy) * fy;
    col_acc[2] += longint'(fx) * fy;
    col_acc[3] += longint'(fx) * ft;
    col_acc[4] += longint'(fy) * ft;
  endfunction

  // Scale to Q7.8, truncate toward zero, saturate to 16 bits
  function automatic logic [15:0] scale_flow(longint num, longint det);
    longint unsigned mag, q;
    longint r;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag << lkof_pkg::FRAC_BITS) / longint'(det);
    if (num < 0) r = (q > 32768) ? -32768 : -longint'(q);
    else r = (q > 32767) ? 32767 : longint'(q);
    return r[15:0];
  endfunction

  // Advance the predictor by one accepted pixel pair
  function automatic void predict_flow(logic [7:0] pa, logic [7:0] pb, logic fs);
    int unsigned w, h, y, x, cur, oth;
    int ca, cb, aa, ab, fx, fy, ft;
    longint t[5];
    longint det, nu, nv;
    flow_beat_t e;
    w = (size_w < 3) ? 3 : ((size_w > lkof_pkg::MAX_WIDTH) ? lkof_pkg::MAX_WIDTH : size_w);
    h = (size_h < 3) ? 3 : size_h;
    ca = pa;
    cb = pb;
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
    end
    if (pos_col >= lkof_pkg::MAX_WIDTH) pos_col = 0;
    y = pos_row;
    x = pos_col;
    aa = line_a[x];
    ab = line_b[x];
    if (y >= 1 && x >= 1) begin
      fx = (aa - upleft_a) + (ca - left_a) + (ab - upleft_b) + (cb - left_b);
      fy = (left_a + ca) - (upleft_a + aa) + (left_b + cb) - (upleft_b + ab);
      ft = (upleft_b + ab + left_b + cb) - (upleft_a + aa + left_a + ca);
      cur = (y & 1) * lkof_pkg::MAX_WIDTH + x;
      oth = ((y + 1) & 1) * lkof_pkg::MAX_WIDTH + x;
      if (y >= 2) begin
        for (int k = 0; k < 5; k++) col_acc[k] = 0;
        // row 0 mirrors row 1: fy changes sign
        if (y == 2) acc_products(grad_x[oth], -grad_y[oth], grad_t[oth]);
        else acc_products(grad_x[cur], grad_y[cur], grad_t[cur]);
        acc_products(grad_x[oth], grad_y[oth], grad_t[oth]);
        acc_products(fx, fy, ft);
        for (int k = 0; k < 5; k++) begin
          col_sums[0][k] = col_sums[1][k];
          col_sums[1][k] = col_sums[2][k];
          col_sums[2][k] = col_acc[k];
        end
        if (x == 1) begin
          // column 0 mirrors column 1: fx changes sign
          col_sums[1][0] = col_acc[0];
          col_sums[1][1] = col_acc[1];
          col_sums[1][2] = -col_acc[2];
          col_sums[1][3] = -col_acc[3];
          col_sums[1][4] = col_acc[4];
        end else begin
          for (int k = 0; k < 5; k++) t[k] = col_sums[0][k] + col_sums[1][k] + col_sums[2][k];
          det = t[0] * t[1] - t[2] * t[2];
          nu = t[2] * t[4] - t[1] * t[3];
          nv = t[3] * t[2] - t[0] * t[4];
          if (det <= 0) begin
            e.u = '0;
            e.v = '0;
            e.singular = 1'b1;
          end else begin
            e.u = scale_flow(nu, det);
            e.v = scale_flow(nv, det);
            e.singular = 1'b0;
          end
          e.row = 12'(y - 1);
          e.col = 10'(x - 1);
          e.last = (y + 1 >= h && x + 1 >= w);
          flow_expected.push_back(e);
        end
      end
      grad_x[cur] = fx;
      grad_y[cur] = fy;
      grad_t[cur] = ft;
    end
    upleft_a = aa;
    upleft_b = ab;
    left_a = ca;
    left_b = cb;
    line_a[x] = pa;
    line_b[x] = pb;
    if (x + 1 >= w) begin
      pos_col = 0;
      pos_row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      pos_col = x + 1;
    end
  endfunction

  // Send one pixel pair; idle first at random, hold until accepted
  task automatic send_pixel(logic [7:0] pa, logic [7:0] pb, logic fs);
    while (!quiet && $urandom_range(99) < 9) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_first <= pa;
    pix.pixel_second <= pb;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    predict_flow(pa, pb, fs);
    items_sent++;
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (flow_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lkof_pkg::reg_idx_t idx, logic [11:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == lkof_pkg::REG_WIDTH) size_w = val[10:0];
    else size_h = val;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    wait_idle();
    write_reg(lkof_pkg::REG_WIDTH, 12'(w));
    write_reg(lkof_pkg::REG_HEIGHT, 12'(h));
  endtask

  // Send one frame of w x h, stopping after cut pixels; smooth content when asked
  task automatic send_frame(int w, int h, bit smooth, bit fs, int cut);
    int gx, gy, a, b, n;
    gx = $urandom_range(0, 12);
    gy = $urandom_range(0, 12);
    n = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (n == cut) return;
        if (smooth) begin
          a = (r * gy + c * gx + $urandom_range(0, 3)) % 256;
          b = a + $urandom_range(0, 6);
          if (b > 255) b = 255;
        end else begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        send_pixel(8'(a), 8'(b), fs && n == 0);
        n++;
      end
    end
  endtask

  task automatic test_directed();
    set_size(3, 3);
    // uniform frames give zero spatial gradients
    for (int i = 0; i < 9; i++) send_pixel(8'd0, 8'd0, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, 8'd0, i == 0);
    // tiny spatial gradient against a huge temporal one drives saturation
    for (int i = 0; i < 9; i++) send_pixel((i == 8) ? 8'd1 : (i == 4 ? 8'd2 : 8'd0),
                                           8'd255, i == 0);
    // frame wrap without frame_start
    send_frame(3, 3, 1'b0, 1'b0, 9);
    // restart mid-frame
    send_frame(3, 3, 1'b1, 1'b1, 4);
    send_frame(3, 3, 1'b0, 1'b1, 9);
  endtask

  task automatic test_size_clamp();
    set_size(0, 0);
    send_frame(3, 3, 1'b0, 1'b1, 9);
  endtask

  task automatic test_tall_frame();
    set_size(4, 4095);
    send_frame(4, 4095, 1'b1, 1'b1, 24);
  endtask

  task automatic test_random_frames();
    int w, h, start;
    bit paused;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < 950) begin
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      set_size(w, h);
      quiet = (items_sent - start > 300 && items_sent - start < 500);
      if ($urandom_range(9) == 0) send_frame(w, h, 1'b0, 1'b1, $urandom_range(1, w * h - 1));
      send_frame(w, h, $urandom_range(1), 1'b1, w * h);
      send_frame(w, h, $urandom_range(1), $urandom_range(1), w * h);
      if (!paused && items_sent - start > 600) begin
        // hold the sender until all results are back
        pix.valid <= 1'b0;
        while (flow_expected.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: stall at random except in quiet stretches
  always @(posedge clk) begin
    if (rst) flow.ready <= 1'b0;
    else flow.ready <= quiet || ($urandom_range(99) >= 9);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    flow_beat_t e;
    if (!rst && flow.valid && flow.ready) begin
      if (flow_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected flow beat row %0d col %0d",
                                       flow.out_row, flow.out_col);
      end else begin
        e = flow_expected.pop_front();
        if (flow.flow_u !== e.u || flow.flow_v !== e.v || flow.out_row !== e.row ||
            flow.out_col !== e.col || flow.singular !== e.singular ||
            flow.last_of_frame !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("flow mismatch: exp u=%0d v=%0d r=%0d c=%0d s=%0b l=%0b, got u=%0d v=%0d r=%0d c=%0d s=%0b l=%0b",
                     $signed(e.u), $signed(e.v), e.row, e.col, e.singular, e.last,
                     flow.flow_u, flow.flow_v, flow.out_row, flow.out_col,
                     flow.singular, flow.last_of_frame);
        end
      end
    end
  end

  // Watchdog
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.pixel_first = '0;
    pix.pixel_second = '0;
    pix.frame_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = lkof_pkg::REG_WIDTH;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_clamp();
    test_tall_frame();
    test_random_frames();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
